/* rtl/plc_pkg.sv */
`timescale 1ns / 1ps
// Shared types, widths and constant tables of the power-law duration codec.
// Depends on nothing; every other file of the block imports it.
package plc_pkg;

    // Fraction bits of the log-domain values and of the mantissas.
    localparam int unsigned FW = 64;
    localparam int unsigned MW = 72;
    // Number of shift-and-add cells in each of the log and exp chains.
    localparam int unsigned NSTEP = 64;
    // Bits of the elaboration-time tables before rounding, and working precision.
    localparam int unsigned RB = 72;
    localparam int unsigned HB = 256;
    // Width of the value whose logarithm is taken.
    localparam int unsigned XW = 28;

    localparam logic [26:0] MAX_DURATION = 27'd120125042;
    localparam logic [15:0] CODE_MAX     = 16'd65535;
    localparam logic [26:0] DUR_MAX      = 27'd134217727;

    // Exponent 1.74 as the ratio 87/50 and its inverse.
    localparam int unsigned ENC_NUM = 50;
    localparam int unsigned ENC_DEN = 87;
    localparam int unsigned DEC_NUM = 87;
    localparam int unsigned DEC_DEN = 50;

    typedef enum logic {
        CMD_ENCODE = 1'b0,
        CMD_DECODE = 1'b1
    } plc_cmd_t;

    // Control that travels beside each item through the cell chains.
    typedef struct packed {
        logic     valid;
        plc_cmd_t cmd;
        logic     clamped;
        logic     zero;
        logic [4:0] expo;
    } plc_side_t;

    // Fraction bits of log2(1 + 2^-k), found by repeated squaring.
    function automatic logic [RB-1:0] plc_log2_bits(input int unsigned k);
        logic [HB+1:0]   y;
        logic [2*HB+3:0] sq;
        logic [RB-1:0]   r;
        y = '0;
        y[HB] = 1'b1;
        y[HB-k] = 1'b1;
        r = '0;
        for (int i = RB - 1; i >= 0; i--) begin
            sq = (2*HB+4)'(y) * (2*HB+4)'(y);
            y  = sq[2*HB+1:HB];
            if (y[HB+1]) begin
                r[i] = 1'b1;
                y    = y >> 1;
            end
        end
        return r;
    endfunction

    // log2(1 + 2^-k) scaled by the exponent of the selected command.
    function automatic logic [FW:0] plc_log_step(input int unsigned k, input logic dec);
        logic [RB-1:0] t;
        logic [RB+7:0] s;
        t = plc_log2_bits(k);
        if (dec) begin
            s = ((RB+8)'(t) * (RB+8)'(DEC_NUM)) / DEC_DEN;
        end else begin
            s = ((RB+8)'(t) * (RB+8)'(ENC_NUM)) / ENC_DEN;
        end
        s = s + (RB+8)'(128);
        return s[FW+8:8];
    endfunction

    // Unscaled log2(1 + 2^-k) for the exponential chain.
    function automatic logic [FW-1:0] plc_exp_step(input int unsigned k);
        logic [RB:0] t;
        t = (RB+1)'(plc_log2_bits(k)) + (RB+1)'(128);
        return t[FW+7:8];
    endfunction

    // Exponent of the selected command with RB fraction bits.
    function automatic logic [RB+1:0] plc_kconst(input logic dec);
        logic [RB+7:0] one_q;
        logic [RB+7:0] r;
        one_q = '0;
        one_q[RB] = 1'b1;
        if (dec) begin
            r = (one_q * (RB+8)'(DEC_NUM)) / DEC_DEN;
        end else begin
            r = (one_q * (RB+8)'(ENC_NUM)) / ENC_DEN;
        end
        return r[RB+1:0];
    endfunction

endpackage

/* rtl/power_law_duration_codec_unit.sv */
`timescale 1ns / 1ps
// Power-law codec top: input, normalization, exponent and output stages, two cell chains.
// Depends on plc_pkg, plc_log_cell and plc_exp_cell.
//
// Usage: each slave transaction carries one item. s_axis_tuser[0] is the command
// (0 encodes duration_us, 1 decodes code_in). Encode clamps the duration to
// 120125042 us and returns round((2d)^(1/1.74)) as a 16-bit code, with
// m_axis_tuser[0] set when the clamp acted. Decode returns floor(code^1.74 / 2).
// Every item gives exactly one master transaction, in order.
// The value is formed as 2^(k * log2(x)): a chain of 64 shift-and-add cells
// takes the logarithm, one stage applies the exponent, and a second chain of
// 64 cells forms the power. There are 132 register stages in all. One
// transaction is taken every cycle unless the receiver stalls a waiting result.
// Reset (aresetn low at a clock edge) empties the pipeline and the output
// register, and s_axis_tready stays low while aresetn is low. When the receiver
// holds m_axis_tready low while a result waits, the chains freeze; the input
// stage still takes one more transaction if it is empty, then s_axis_tready
// drops until the result is taken.
module power_law_duration_codec_unit import plc_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [79:0] s_axis_tdata,  // duration_us [63:0], code_in [79:64]
    input  logic [0:0]  s_axis_tuser,  // command [0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,  // code_out [15:0], duration_out [42:16], zeros [47:43]
    output logic [0:0]  m_axis_tuser   // clamped [0]
);

    localparam logic [RB+1:0] K_ENC_Q = plc_kconst(1'b0);
    localparam logic [RB+1:0] K_DEC_Q = plc_kconst(1'b1);
    localparam logic [FW+4:0] ONE_E   = {5'd1, {FW{1'b0}}};
    localparam logic [MW+1:0] ONE_P   = {2'b01, {MW{1'b0}}};

    // The whole pipeline moves together unless a result waits at a stalled receiver.
    logic adv;
    logic in_accept;

    // Input stage: command decode, clamp and the value x whose log is taken.
    plc_side_t      a_side_reg, a_side_next;
    logic [XW-1:0]  a_x_reg, a_x_next;

    // Normalization stage.
    plc_side_t      b_side_reg, b_side_next;
    logic [MW:0]    b_m_reg, b_m_next;
    logic [4:0]     b_e;
    logic [XW-1:0]  b_norm;

    // Cell chains; entry 0 is the stage feeding the first cell.
    plc_side_t      lg_side [NSTEP+1];
    logic [MW:0]    lg_m    [NSTEP+1];
    logic [FW+1:0]  lg_acc  [NSTEP+1];
    plc_side_t      ex_side [NSTEP+1];
    logic [FW-1:0]  ex_f    [NSTEP+1];
    logic [MW+1:0]  ex_p    [NSTEP+1];

    // Exponent stage between the chains.
    plc_side_t      br_side_reg, br_side_next;
    logic [FW-1:0]  br_f_reg, br_f_next;
    logic [RB+1:0]  br_kq;
    logic [RB+7:0]  br_prod;
    logic [FW+4:0]  br_kint;
    logic [FW+4:0]  br_e;

    // Output register.
    logic           m_valid_reg;
    logic [15:0]    code_reg, code_next;
    logic [26:0]    dur_reg, dur_next;
    logic           clamped_reg;
    logic [MW+33:0] ysh;
    logic [33:0]    yint;
    logic           yhalf;

    assign adv           = !m_valid_reg || m_axis_tready;
    assign s_axis_tready = aresetn && (adv || !a_side_reg.valid);
    assign in_accept     = s_axis_tvalid && s_axis_tready;

    // Input stage.
    always_comb begin
        logic        over;
        logic [26:0] dclamp;
        a_side_next         = '0;
        a_side_next.valid   = in_accept;
        a_side_next.cmd     = plc_cmd_t'(s_axis_tuser[0]);
        over                = s_axis_tdata[63:0] > 64'(MAX_DURATION);
        dclamp              = over ? MAX_DURATION : s_axis_tdata[26:0];
        if (a_side_next.cmd == CMD_DECODE) begin
            a_x_next            = {12'd0, s_axis_tdata[79:64]};
            a_side_next.zero    = s_axis_tdata[79:64] <= 16'd1;
            a_side_next.clamped = 1'b0;
        end else begin
            a_x_next            = {dclamp, 1'b0};
            a_side_next.zero    = s_axis_tdata[63:0] == 64'd0;
            a_side_next.clamped = over;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_side_reg <= '0;
        end else if (adv || !a_side_reg.valid) begin
            a_side_reg <= a_side_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv || !a_side_reg.valid) begin
            a_x_reg <= a_x_next;
        end
    end

    // Normalization: x = 2^e * m with m in [1, 2).
    always_comb begin
        b_e = '0;
        for (int i = 0; i < XW; i++) begin
            if (a_x_reg[i]) begin
                b_e = 5'(i);
            end
        end
        b_norm           = a_x_reg << (5'(XW - 1) - b_e);
        b_m_next         = {b_norm, {(MW - XW + 1){1'b0}}};
        b_side_next      = a_side_reg;
        b_side_next.expo = b_e;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_side_reg <= '0;
        end else if (adv) begin
            b_side_reg <= b_side_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            b_m_reg <= b_m_next;
        end
    end

    assign lg_side[0] = b_side_reg;
    assign lg_m[0]    = b_m_reg;
    assign lg_acc[0]  = '0;

    // Each cell multiplies the mantissa toward two and sums the scaled logs it used.
    for (genvar g = 1; g <= NSTEP; g++) begin : g_log
        plc_log_cell #(
            .STEP(g)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .side_in (lg_side[g-1]),
            .m_in    (lg_m[g-1]),
            .acc_in  (lg_acc[g-1]),
            .side_out(lg_side[g]),
            .m_out   (lg_m[g]),
            .acc_out (lg_acc[g])
        );
    end

    // k * log2(x) = k * (e + 1) - sum of the scaled steps; decode also halves.
    always_comb begin
        br_kq   = (lg_side[NSTEP].cmd == CMD_DECODE) ? K_DEC_Q : K_ENC_Q;
        br_prod = (RB+8)'(lg_side[NSTEP].expo + 6'd1) * (RB+8)'(br_kq);
        br_kint = br_prod[RB+4:RB-FW];
        br_e    = br_kint - {3'd0, lg_acc[NSTEP]};
        if (lg_side[NSTEP].cmd == CMD_DECODE) begin
            br_e = br_e - ONE_E;
        end
        br_side_next      = lg_side[NSTEP];
        br_side_next.expo = br_e[FW+4:FW];
        br_f_next         = br_e[FW-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            br_side_reg <= '0;
        end else if (adv) begin
            br_side_reg <= br_side_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            br_f_reg <= br_f_next;
        end
    end

    assign ex_side[0] = br_side_reg;
    assign ex_f[0]    = br_f_reg;
    assign ex_p[0]    = ONE_P;

    // Each cell forms 2^f of the fraction by shift-and-add factors.
    for (genvar g = 1; g <= NSTEP; g++) begin : g_exp
        plc_exp_cell #(
            .STEP(g)
        ) u_cell (
            .aclk    (aclk),
            .aresetn (aresetn),
            .en      (adv),
            .side_in (ex_side[g-1]),
            .f_in    (ex_f[g-1]),
            .p_in    (ex_p[g-1]),
            .side_out(ex_side[g]),
            .f_out   (ex_f[g]),
            .p_out   (ex_p[g])
        );
    end

    // Scale by the integer part, then round (encode) or truncate (decode).
    always_comb begin
        ysh   = {32'd0, ex_p[NSTEP]} << ex_side[NSTEP].expo;
        yint  = ysh[MW+33:MW];
        yhalf = ysh[MW-1];
        code_next = '0;
        dur_next  = '0;
        if (!ex_side[NSTEP].zero) begin
            if (ex_side[NSTEP].cmd == CMD_ENCODE) begin
                if (yint >= 34'(CODE_MAX)) begin
                    code_next = CODE_MAX;
                end else begin
                    code_next = yint[15:0] + {15'd0, yhalf};
                end
            end else begin
                if (yint > 34'(DUR_MAX)) begin
                    dur_next = DUR_MAX;
                end else begin
                    dur_next = yint[26:0];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= ex_side[NSTEP].valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            code_reg    <= code_next;
            dur_reg     <= dur_next;
            clamped_reg <= ex_side[NSTEP].clamped;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {5'd0, dur_reg, code_reg};
    assign m_axis_tuser  = clamped_reg;

    // A clamped duration always encodes to the top code and never carries a decode value.
    a_clamp_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[0] |->
            m_axis_tdata[15:0] == CODE_MAX && m_axis_tdata[42:16] == 27'd0)
        else $error("clamped result without the top code");

    // Input back-pressure only comes from a waiting result with a full input stage.
    a_stall_src: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready && a_side_reg.valid)
        else $error("input stalled without a stalled output");

    // The integer part of the exponent stays within the duration range.
    a_expo_range: assert property (@(posedge aclk) disable iff (!aresetn)
        br_side_reg.valid && !br_side_reg.zero |-> br_side_reg.expo <= 5'd27)
        else $error("exponent integer part out of range");

endmodule

/* rtl/plc_log_cell.sv */
`timescale 1ns / 1ps
// One cell of the logarithm chain: tries the factor (1 + 2^-STEP) on the mantissa.
// Depends on plc_pkg for widths, the side struct and the step constants.
module plc_log_cell import plc_pkg::*; #(
    parameter int unsigned STEP = 1
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  plc_side_t       side_in,
    input  logic [MW:0]     m_in,
    input  logic [FW+1:0]   acc_in,
    output plc_side_t       side_out,
    output logic [MW:0]     m_out,
    output logic [FW+1:0]   acc_out
);

    localparam logic [FW:0] STEP_ENC = plc_log_step(STEP, 1'b0);
    localparam logic [FW:0] STEP_DEC = plc_log_step(STEP, 1'b1);

    plc_side_t       side_reg;
    logic [MW:0]     m_reg, m_next;
    logic [FW+1:0]   acc_reg, acc_next;
    logic [MW+1:0]   cand;
    logic [FW:0]     step_val;

    // The factor is taken while the product stays below two.
    always_comb begin
        cand     = {1'b0, m_in} + {1'b0, m_in >> STEP};
        step_val = (side_in.cmd == CMD_DECODE) ? STEP_DEC : STEP_ENC;
        if (!cand[MW+1]) begin
            m_next   = cand[MW:0];
            acc_next = acc_in + {1'b0, step_val};
        end else begin
            m_next   = m_in;
            acc_next = acc_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= '0;
        end else if (en) begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            m_reg   <= m_next;
            acc_reg <= acc_next;
        end
    end

    assign side_out = side_reg;
    assign m_out    = m_reg;
    assign acc_out  = acc_reg;

endmodule

/* rtl/plc_exp_cell.sv */
`timescale 1ns / 1ps
// One cell of the exponential chain: spends log2(1 + 2^-STEP) of the fraction.
// Depends on plc_pkg for widths, the side struct and the step constants.
module plc_exp_cell import plc_pkg::*; #(
    parameter int unsigned STEP = 1
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  plc_side_t       side_in,
    input  logic [FW-1:0]   f_in,
    input  logic [MW+1:0]   p_in,
    output plc_side_t       side_out,
    output logic [FW-1:0]   f_out,
    output logic [MW+1:0]   p_out
);

    localparam logic [FW-1:0] STEP_T = plc_exp_step(STEP);

    plc_side_t       side_reg;
    logic [FW-1:0]   f_reg, f_next;
    logic [MW+1:0]   p_reg, p_next;

    always_comb begin
        if (f_in >= STEP_T) begin
            f_next = f_in - STEP_T;
            p_next = p_in + (p_in >> STEP);
        end else begin
            f_next = f_in;
            p_next = p_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg <= '0;
        end else if (en) begin
            side_reg <= side_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f_reg <= f_next;
            p_reg <= p_next;
        end
    end

    assign side_out = side_reg;
    assign f_out    = f_reg;
    assign p_out    = p_reg;

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Self-checking testbench of power_law_duration_codec_unit: directed and random items.
// Depends on plc_pkg and the codec RTL. Expectations come from exact wide-integer powers.
module testbench;
    import plc_pkg::*;

    localparam int unsigned CYCLE_LIMIT    = 300000;
    localparam int unsigned RANDOM_ITEMS   = 1200;
    localparam int unsigned HOLD_AFTER     = 300;
    localparam int unsigned HOLD_CYCLES    = 600;
    localparam int unsigned DRAIN_CYCLES   = 200;
    localparam int unsigned MAX_REPORTED   = 10;

    // One input item and one result, field by field.
    typedef struct packed {
        plc_cmd_t    cmd;
        logic [63:0] dur;
        logic [15:0] code;
    } codec_item_t;

    typedef struct packed {
        logic [15:0] code;
        logic [26:0] dur;
        logic        clamped;
    } codec_result_t;

    // The exact comparisons need powers up to about 1490 bits.
    typedef bit [1535:0] wide_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [79:0] s_axis_tdata = '0;   // duration_us [63:0], code_in [79:64]
    logic [0:0]  s_axis_tuser = '0;   // command [0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;        // code_out [15:0], duration_out [42:16], zeros [47:43]
    logic [0:0]  m_axis_tuser;        // clamped [0]

    codec_item_t   pending_items[$];
    codec_result_t expected_results[$];

    codec_item_t next_item;
    logic        send_busy = 1'b0;
    logic        send_fired = 1'b0;
    logic        sender_quiet = 1'b0;
    int unsigned send_gap = 0;

    logic        recv_fired = 1'b0;
    logic        receiver_quiet = 1'b0;
    int unsigned recv_wait = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;

    int unsigned results_taken = 0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    power_law_duration_codec_unit u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 aclk = ~aclk;

    // base^e by left-to-right square and multiply; e stays below 128.
    function automatic wide_t wide_pow(input longint unsigned base, input bit [6:0] e);
        wide_t acc;
        wide_t b;
        acc = wide_t'(1);
        b = wide_t'(base);
        for (int k = 6; k >= 0; k--) begin
            acc = acc * acc;
            if (e[k]) begin
                acc = acc * b;
            end
        end
        return acc;
    endfunction

    // Largest code c with c == 0 or (2c-1)^87 <= 2^87 * (2d)^50. A floating-point
    // estimate lands next to the answer, and the exact test settles the last step.
    function automatic logic [15:0] encode_duration(input longint unsigned d);
        wide_t bound;
        real   est;
        int    c;
        bound = wide_pow(2 * d, 7'd50) << 87;
        est = (2.0 * real'(d)) ** (50.0 / 87.0);
        c = int'(est);
        if (c < 0) begin
            c = 0;
        end
        if (c > int'(CODE_MAX)) begin
            c = int'(CODE_MAX);
        end
        while (c < int'(CODE_MAX) && wide_pow(longint'(2 * c + 1), 7'd87) <= bound) begin
            c = c + 1;
        end
        while (c > 0 && wide_pow(longint'(2 * c - 1), 7'd87) > bound) begin
            c = c - 1;
        end
        return c[15:0];
    endfunction

    // Largest n with (2n)^50 <= code^87, bounded to 27 bits.
    function automatic logic [26:0] decode_code(input logic [15:0] c);
        wide_t  bound;
        longint n;
        bound = wide_pow(longint'(c), 7'd87);
        n = $rtoi((real'(c) ** (87.0 / 50.0)) / 2.0);
        if (n < 0) begin
            n = 0;
        end
        if (n > longint'(DUR_MAX)) begin
            n = longint'(DUR_MAX);
        end
        while (n < longint'(DUR_MAX) && wide_pow(2 * (n + 1), 7'd50) <= bound) begin
            n = n + 1;
        end
        while (n > 0 && wide_pow(2 * n, 7'd50) > bound) begin
            n = n - 1;
        end
        return n[26:0];
    endfunction

    function automatic codec_result_t predict_codec(input codec_item_t it);
        codec_result_t r;
        r = '0;
        if (it.cmd == CMD_ENCODE) begin
            if (it.dur > 64'(MAX_DURATION)) begin
                r.clamped = 1'b1;
                r.code = encode_duration(64'(MAX_DURATION));
            end else begin
                r.code = encode_duration(it.dur);
            end
        end else begin
            r.dur = decode_code(it.code);
        end
        return r;
    endfunction

    function automatic codec_item_t make_item(input plc_cmd_t cmd, input logic [63:0] dur,
                                              input logic [15:0] code);
        codec_item_t it;
        it.cmd = cmd;
        it.dur = dur;
        it.code = code;
        return it;
    endfunction

    task automatic report_error(input string msg);
        error_count = error_count + 1;
        if (error_count <= MAX_REPORTED) begin
            $display("%s", msg);
        end
    endtask

    // The driver changes inputs at the falling edge. A transaction seen at the last
    // rising edge frees the slot, and the next item follows after its drawn gap.
    // During the long receiver hold the sender keeps offering with no gaps, so the
    // pipeline fills and s_axis_tready has to drop.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (send_busy && send_fired) begin
                send_busy = 1'b0;
            end
            if (!send_busy) begin
                if (send_gap > 0) begin
                    send_gap = send_gap - 1;
                end else if (pending_items.size() > 0) begin
                    next_item = pending_items.pop_front();
                    s_axis_tdata <= {next_item.code, next_item.dur};
                    s_axis_tuser <= next_item.cmd;
                    send_busy = 1'b1;
                    if ($urandom_range(0, 39) == 0) begin
                        sender_quiet = !sender_quiet;
                    end
                    send_gap = (sender_quiet || hold_left > 0) ? 0 : $urandom_range(0, 14);
                end
            end
            s_axis_tvalid <= send_busy;
        end
    end

    // The receiver draws a stall before each result, with stretches of none.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (m_axis_tready && recv_fired) begin
                if ($urandom_range(0, 39) == 0) begin
                    receiver_quiet = !receiver_quiet;
                end
                recv_wait = receiver_quiet ? 0 : $urandom_range(0, 14);
            end
            if (hold_left > 0) begin
                m_axis_tready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait = recv_wait - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // One long hold-off of the result channel, started once enough results came.
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && results_taken >= HOLD_AFTER) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    // The monitor samples both channels at the rising edge. An accepted input
    // transaction queues its expected result; an accepted output transaction is
    // checked against the oldest one waiting.
    always @(posedge aclk) begin
        codec_result_t got;
        codec_result_t want;
        send_fired <= s_axis_tvalid && s_axis_tready;
        recv_fired <= m_axis_tvalid && m_axis_tready;
        if (aresetn) begin
            if (s_axis_tvalid && s_axis_tready) begin
                expected_results.push_back(predict_codec(make_item(
                    plc_cmd_t'(s_axis_tuser[0]), s_axis_tdata[63:0], s_axis_tdata[79:64])));
            end
            if (m_axis_tvalid && m_axis_tready) begin
                got.code = m_axis_tdata[15:0];
                got.dur = m_axis_tdata[42:16];
                got.clamped = m_axis_tuser[0];
                results_taken <= results_taken + 1;
                if (expected_results.size() == 0) begin
                    report_error($sformatf("unexpected result: code %0d duration %0d clamped %0d",
                                           got.code, got.dur, got.clamped));
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        report_error($sformatf(
                            "result %0d: code %0d/%0d duration %0d/%0d clamped %0d/%0d (exp/act)",
                            results_taken, want.code, got.code, want.dur, got.dur,
                            want.clamped, got.clamped));
                    end
                end
            end
        end
    end

    // A run that stops making progress ends here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("power_law_duration_codec_unit regression: fail");
            $finish;
        end
    end

    initial begin
        longint      d;
        int          c;
        real         edge_val;
        logic [63:0] noise;

        // Directed items: zero inputs, the clamp boundary, the widest durations,
        // and the extreme codes, some with the unused field of the command nonzero.
        pending_items.push_back(make_item(CMD_ENCODE, 64'd0, 16'hFFFF));
        pending_items.push_back(make_item(CMD_ENCODE, 64'd1, 16'd0));
        pending_items.push_back(make_item(CMD_ENCODE, 64'd2, 16'd0));
        pending_items.push_back(make_item(CMD_ENCODE, 64'd120125041, 16'd0));
        pending_items.push_back(make_item(CMD_ENCODE, 64'd120125042, 16'd0));
        pending_items.push_back(make_item(CMD_ENCODE, 64'd120125043, 16'd0));
        pending_items.push_back(make_item(CMD_ENCODE, 64'd134217727, 16'd0));
        pending_items.push_back(make_item(CMD_ENCODE, 64'h8000_0000_0000_0000, 16'd0));
        pending_items.push_back(make_item(CMD_ENCODE, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0));
        pending_items.push_back(make_item(CMD_ENCODE, 64'h0000_0001_0000_0000, 16'd0));
        pending_items.push_back(make_item(CMD_DECODE, 64'hFFFF_FFFF_FFFF_FFFF, 16'd0));
        pending_items.push_back(make_item(CMD_DECODE, 64'd0, 16'd1));
        pending_items.push_back(make_item(CMD_DECODE, 64'd0, 16'd2));
        pending_items.push_back(make_item(CMD_DECODE, 64'd0, 16'd3));
        pending_items.push_back(make_item(CMD_DECODE, 64'd0, 16'd32768));
        pending_items.push_back(make_item(CMD_DECODE, 64'd0, 16'd65534));
        pending_items.push_back(make_item(CMD_DECODE, 64'd0, 16'd65535));

        // Random items. Encodes mix full-width, log-spread, near-clamp and small values,
        // values in range and values next to a rounding threshold of some code.
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            noise = {$urandom, $urandom};
            if ($urandom_range(0, 1) == 0) begin
                case ($urandom_range(0, 5))
                    0: d = longint'(noise);
                    1: d = longint'(noise >> $urandom_range(0, 63));
                    2: d = 120125042 + $urandom_range(0, 8) - 4;
                    3: begin
                        c = $urandom_range(1, 65535);
                        edge_val = ((real'(c) - 0.5) ** (87.0 / 50.0)) / 2.0;
                        d = longint'($rtoi(edge_val)) + $urandom_range(0, 4) - 2;
                        if (d < 0) begin
                            d = 0;
                        end
                    end
                    4: d = $urandom_range(0, 2000);
                    default: d = $urandom_range(0, 120125042);
                endcase
                pending_items.push_back(make_item(CMD_ENCODE, 64'(d), 16'($urandom)));
            end else begin
                case ($urandom_range(0, 3))
                    0: c = $urandom_range(0, 65535);
                    1: c = $urandom_range(0, 40);
                    2: c = $urandom_range(65500, 65535);
                    default: c = $urandom_range(0, 65535) >> $urandom_range(0, 15);
                endcase
                pending_items.push_back(make_item(CMD_DECODE, noise, 16'(c)));
            end
        end

        // Synchronous reset, released at a falling edge.
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        while (pending_items.size() > 0 || send_busy) begin
            @(posedge aclk);
        end
        while (expected_results.size() > 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && expected_results.size() == 0) begin
            $display("power_law_duration_codec_unit regression: pass");
        end else begin
            $display("power_law_duration_codec_unit regression: fail");
        end
        $finish;
    end

endmodule
